>>> src/sha_pkg.sv
// Package for the SHA-256 byte stream hasher.
// Holds round constants, initial hash values, padding constants and the rotate/schedule functions.
// No dependencies.
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PadMark  = 8'h80;
  localparam logic [5:0]  LenPos   = 6'd56;
  localparam logic [60:0] CountMax = {61{1'b1}};

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Next schedule word from the 16-word window (w[0] oldest).
  function automatic word_t sched(input word_t w16, input word_t w15,
                                 input word_t w7, input word_t w2);
    word_t sa;
    word_t sb;
    sa = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    sb = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    sched = w16 + sa + w7 + sb;
  endfunction

endpackage

>>> src/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher, top level.
// Depends on sha_pkg for constants and the rotate and schedule functions.
//
//  channel | direction | handshake        | payload
//  in      | sink      | in_valid/in_stall| data_byte, byte_valid, end_of_message
//  out     | source    | out_valid/out_stall | digest_word, word_index, last_word,
//          |           |                  |   length_error
//
// A plain byte is accepted, then written into the block memory.
// A byte that fills a block adds a load step, 64 rounds and a fold step,
// one round per cycle over the block memory read port. An end beat walks the
// padding bytes one per cycle and compresses one or two more blocks, then
// streams eight digest beats, one per cycle while out_stall is low.
// Reset is synchronous; block memory contents are not cleared. A stalled
// digest beat holds its payload; input stays stalled until the digest drains.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        length_error
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUT  = 3'd1;  // write one byte into block memory
  localparam logic [2:0] S_PAD  = 3'd2;  // generate padding bytes
  localparam logic [2:0] S_LOAD = 3'd3;  // prime word reads
  localparam logic [2:0] S_RND  = 3'd4;  // 64 rounds
  localparam logic [2:0] S_FOLD = 3'd5;  // add working vars into hash
  localparam logic [2:0] S_OUT  = 3'd6;  // stream digest

  logic [2:0]  state;
  logic [7:0]  pend_byte;
  logic        pend_end;      // end-of-message still to process
  logic        padding;       // inside padding sequence
  logic        pad_first;     // next pad byte is the 0x80 mark
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        ovf;
  logic [63:0] bit_len;

  sha_pkg::word_t hash [8];
  sha_pkg::word_t v [8];
  sha_pkg::word_t win [16];
  logic [6:0]  rnd;
  logic [2:0]  oidx;

  // Block memory: 16 words of 4 bytes, one byte lane write, word read.
  logic [7:0]  mem0 [16];
  logic [7:0]  mem1 [16];
  logic [7:0]  mem2 [16];
  logic [7:0]  mem3 [16];
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic [3:0]  mem_raddr;
  sha_pkg::word_t mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      case (mem_waddr[1:0])
        2'd0: mem0[mem_waddr[5:2]] <= mem_wdata;
        2'd1: mem1[mem_waddr[5:2]] <= mem_wdata;
        2'd2: mem2[mem_waddr[5:2]] <= mem_wdata;
        default: mem3[mem_waddr[5:2]] <= mem_wdata;
      endcase
    end
    mem_rdata <= {mem0[mem_raddr], mem1[mem_raddr], mem2[mem_raddr], mem3[mem_raddr]};
  end

  // Pad byte for the current fill position.
  logic [7:0] pad_byte;
  logic [5:0] lp;
  always_comb begin
    lp = fill - sha_pkg::LenPos;
    if (pad_first) begin
      pad_byte = sha_pkg::PadMark;
    end else if (fill >= sha_pkg::LenPos && !pend_end) begin
      pad_byte = bit_len[8'(63 - 8 * int'(lp[2:0])) -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign mem_we = (state == S_PUT) || (state == S_PAD);
  assign mem_waddr = fill;
  assign mem_wdata = (state == S_PUT) ? pend_byte : pad_byte;
  assign mem_raddr = (state == S_LOAD) ? 4'd0 : rnd[3:0] + 4'd1;

  // Current schedule word: block word for rounds 0..15, else expansion.
  sha_pkg::word_t wcur;
  always_comb begin
    if (rnd < 7'd16) wcur = mem_rdata;
    else wcur = sha_pkg::sched(win[0], win[1], win[9], win[14]);
  end

  sha_pkg::word_t t1, t2;
  always_comb begin
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[rnd[5:0]] + wcur;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      msg_bytes <= '0;
      ovf <= 1'b0;
      pend_end <= 1'b0;
      padding <= 1'b0;
      pad_first <= 1'b0;
      rnd <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::InitH[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_byte <= data_byte;
            pend_end <= end_of_message;
            if (byte_valid) begin
              // hold the count at its top and flag it
              if (msg_bytes == sha_pkg::CountMax) ovf <= 1'b1;
              else msg_bytes <= msg_bytes + 61'd1;
              state <= S_PUT;
            end else if (end_of_message) begin
              state <= S_PAD;
              padding <= 1'b1;
              pad_first <= 1'b1;
              bit_len <= {msg_bytes, 3'b000};
            end
          end
        end
        S_PUT: begin
          fill <= fill + 6'd1;
          bit_len <= {msg_bytes, 3'b000};
          if (fill == 6'd63) begin
            state <= S_LOAD;
          end else if (pend_end) begin
            state <= S_PAD;
            padding <= 1'b1;
            pad_first <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          pad_first <= 1'b0;
          // pend_end marks that the length block is still ahead
          if (pad_first) pend_end <= (fill > sha_pkg::LenPos - 6'd1);
          if (fill == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin
          rnd <= '0;
          for (int i = 0; i < 8; i++) v[i] <= hash[i];
          state <= S_RND;
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= wcur;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          if (!padding) begin
            // a byte that filled the block may also end the message
            if (pend_end) begin
              state <= S_PAD;
              padding <= 1'b1;
              pad_first <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end else if (pend_end) begin
            pend_end <= 1'b0;
            state <= S_PAD;
          end else begin
            oidx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= S_IDLE;
              padding <= 1'b0;
              msg_bytes <= '0;
              ovf <= 1'b0;
              fill <= '0;
              for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::InitH[i];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = (state == S_OUT);
  assign digest_word  = hash[oidx];
  assign word_index   = oidx;
  assign last_word    = (oidx == 3'd7);
  assign length_error = ovf;

  // Digest beats come only out of the output state, in order.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest index skipped");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid && hash[0] == sha_pkg::InitH[0])
    else $error("hash not restored after digest");
  assert property (@(posedge clk) disable iff (rst)
    state == S_RND && rnd == 7'd63 |=> state == S_FOLD)
    else $error("round count broken");
endmodule
